FILE: rtl/sliding_anagram_counter_macros.svh
// Assertion helpers for the top-level RTL file.
`ifndef SLIDING_ANAGRAM_COUNTER_MACROS_SVH
`define SLIDING_ANAGRAM_COUNTER_MACROS_SVH

`ifndef SYNTHESIS
// Condition must hold at every clock edge outside reset.
`define SAC_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Antecedent implies consequent in the same cycle.
`define SAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define SAC_ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define SAC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`endif

`endif

FILE: rtl/sac_pkg.sv
`timescale 1ns / 1ps

package sac_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int ALPHABET    = 26;
   localparam int LETTER_W    = 5;
   localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
   localparam int POS_W       = $clog2(MAX_PATTERN);
   localparam int HIST_AW     = $clog2(ALPHABET);
   // window count minus pattern count, kept modulo 2**DIFF_W
   localparam int DIFF_W      = LEN_W + 1;
   localparam int NZ_W        = $clog2(ALPHABET + 1);
   localparam int TOTAL_W     = 32;

   typedef enum logic [1:0] {
      OP_CLEAR   = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } op_type;

   // action after validation of the incoming word
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_CLEAR,
      ACT_PATTERN,
      ACT_TEXT
   } act_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [LETTER_W-1:0] letter;
   } req_type;

   typedef struct packed {
      logic               window_full;
      logic               is_match;
      logic [TOTAL_W-1:0] match_total;
   } rsp_type;

   // one item on its way from the front end to the histogram stage
   typedef struct packed {
      logic                valid;
      act_type             act;
      logic                remove;
      logic                full;
      logic [LETTER_W-1:0] letter;
   } item_type;

endpackage

FILE: rtl/sliding_anagram_counter.sv
// Channel  Handshake              Dir  Word
// req      req_valid, req_ready   in   req_type {op, letter}
// rsp      rsp_valid, rsp_ready   out  rsp_type {window_full, is_match, match_total}
//
// One word per cycle while the output is not held, set by the read-modify-write
// of the histogram memories, which forward the previous write to the next word.
// A word's result reaches rsp through the ring read, the histogram read and the
// output register; one result word per request word.
// Reset clears counters, valid flags and the total at once; no clearing pass.
// While the output word waits and rsp_ready is low, the whole pipeline holds.
`timescale 1ns / 1ps
`include "sliding_anagram_counter_macros.svh"

module sliding_anagram_counter
   import sac_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic                adv;
   logic                accept;
   logic                letter_ok;
   act_type             act;
   logic                remove;
   logic                full_next;
   logic [LEN_W-1:0]    pos_ext;
   logic [POS_W-1:0]    old_idx;

   logic [LEN_W-1:0]    plen_ff, plen_in;
   logic [LEN_W-1:0]    fill_ff, fill_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   item_type            item_ff, item_in;
   logic [LETTER_W-1:0] ring_rdata;

   logic                s2_valid;
   rsp_type             s2_rsp;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   // pipeline advances unless the output word is held
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;
   assign letter_ok = req_data.letter < LETTER_W'(ALPHABET);

   // decode
   always_comb begin
      act = ACT_NONE;
      unique case (req_data.op)
         OP_CLEAR: begin
            act = ACT_CLEAR;
         end
         OP_PATTERN: begin
            if (letter_ok && (plen_ff < LEN_W'(MAX_PATTERN))) act = ACT_PATTERN;
         end
         OP_TEXT: begin
            if (letter_ok && (plen_ff != '0)) act = ACT_TEXT;
         end
         default: begin
            act = ACT_NONE;
         end
      endcase
   end

   // oldest letter sits fill places behind the write position
   always_comb begin
      remove  = (act == ACT_TEXT) && (fill_ff == plen_ff);
      pos_ext = LEN_W'(pos_ff);
      if (pos_ext >= fill_ff) begin
         old_idx = POS_W'(pos_ext - fill_ff);
      end else begin
         old_idx = POS_W'(pos_ext + LEN_W'(MAX_PATTERN) - fill_ff);
      end
   end

   // window counters
   always_comb begin
      plen_in = plen_ff;
      fill_in = fill_ff;
      pos_in  = pos_ff;
      if (accept) begin
         case (act)
            ACT_CLEAR: begin
               plen_in = '0;
               fill_in = '0;
               pos_in  = '0;
            end
            ACT_PATTERN: begin
               plen_in = plen_ff + LEN_W'(1);
            end
            ACT_TEXT: begin
               pos_in = (pos_ff == POS_W'(MAX_PATTERN - 1)) ? '0 : pos_ff + POS_W'(1);
               if (!remove) fill_in = fill_ff + LEN_W'(1);
            end
            default: ;
         endcase
      end
      full_next = (plen_in != '0) && (fill_in == plen_in);
      item_in   = '{valid: accept, act: act, remove: remove, full: full_next,
                    letter: req_data.letter};
   end

   sac_ram #(.WIDTH(LETTER_W), .DEPTH(MAX_PATTERN), .RD_PORTS(1)) u_ring (
      .clock (clock),
      .we    (accept && (act == ACT_TEXT)),
      .waddr (pos_ff),
      .wdata (req_data.letter),
      .re    (adv),
      .raddr (old_idx),
      .rdata (ring_rdata)
   );

   sac_hist u_hist (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .s1_item  (item_ff),
      .s1_old   (ring_rdata),
      .s2_valid (s2_valid),
      .s2_rsp   (s2_rsp)
   );

   // output register
   assign rsp_valid_in = adv ? s2_valid : rsp_valid_ff;
   assign rsp_data_in  = adv ? s2_rsp : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plen_ff       <= '0;
         fill_ff       <= '0;
         pos_ff        <= '0;
         item_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         plen_ff      <= plen_in;
         fill_ff      <= fill_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SAC_ASSERT_ALWAYS(a_fill_le_len, clock, reset, fill_ff <= plen_ff, "window fill above pattern length")
   `SAC_ASSERT_ALWAYS(a_len_le_max, clock, reset, plen_ff <= LEN_W'(MAX_PATTERN), "pattern length above ring depth")
   `SAC_ASSERT_IMPLY(a_match_full, clock, reset, rsp_valid_ff && rsp_data_ff.is_match, rsp_data_ff.window_full, "match on a window that is not full")

endmodule

FILE: rtl/sac_ram.sv
`timescale 1ns / 1ps

module sac_ram #(
   parameter int WIDTH    = 8,
   parameter int DEPTH    = 32,
   parameter int RD_PORTS = 1,
   localparam int AW      = $clog2(DEPTH)
) (
   input  logic                               clock,
   input  logic                               we,
   input  logic [AW-1:0]                      waddr,
   input  logic [WIDTH-1:0]                   wdata,
   input  logic                               re,
   input  logic [RD_PORTS-1:0][AW-1:0]        raddr,
   output logic [RD_PORTS-1:0][WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0]                 mem_ff [DEPTH];
   logic [RD_PORTS-1:0][WIDTH-1:0]   rdata_ff;

   // one write port, registered reads return the old contents on a collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         for (int p = 0; p < RD_PORTS; p++) begin
            rdata_ff[p] <= mem_ff[raddr[p]];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sac_hist.sv
`timescale 1ns / 1ps

module sac_hist
   import sac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  item_type            s1_item,
   input  logic [LETTER_W-1:0] s1_old,
   output logic                s2_valid,
   output rsp_type             s2_rsp
);

   typedef struct packed {
      logic               valid;
      logic [HIST_AW-1:0] addr;
      logic [DIFF_W-1:0]  data;
   } fwd_type;

   // A counts window insertions minus pattern letters, B counts window removals
   logic [1:0][DIFF_W-1:0]  a_rd;
   logic [1:0][DIFF_W-1:0]  b_rd;
   logic [1:0][HIST_AW-1:0] rd_addr;

   item_type                s2_item_ff, s2_item_in;
   logic [HIST_AW-1:0]      s2_old_ff, s2_old_in;
   logic [ALPHABET-1:0]     va_ff, va_in;
   logic [ALPHABET-1:0]     vb_ff, vb_in;
   fwd_type                 fwd_a_ff, fwd_a_in;
   fwd_type                 fwd_b_ff, fwd_b_in;
   logic [NZ_W-1:0]         nz_ff, nz_in;
   logic [TOTAL_W-1:0]      total_ff, total_in;

   logic [HIST_AW-1:0]      let_a;
   logic [DIFF_W-1:0]       a_l, b_l, a_o, b_o;
   logic [DIFF_W-1:0]       d_l, d_o, dl_inc, dl_dec, do_dec;
   logic                    same;
   logic                    a_we, b_we;
   logic [DIFF_W-1:0]       a_wdata, b_wdata;
   logic                    match;

   // forwarded value from the previous write, else memory, else reset value
   function automatic logic [DIFF_W-1:0] pick(fwd_type f, logic [HIST_AW-1:0] addr,
                                              logic vbit, logic [DIFF_W-1:0] rd);
      logic [DIFF_W-1:0] res;
      if (f.valid && (f.addr == addr)) begin
         res = f.data;
      end else if (vbit) begin
         res = rd;
      end else begin
         res = '0;
      end
      return res;
   endfunction

   // port 0 reads the new letter, port 1 the letter leaving the window
   assign rd_addr = {s1_old[HIST_AW-1:0], s1_item.letter[HIST_AW-1:0]};

   sac_ram #(.WIDTH(DIFF_W), .DEPTH(ALPHABET), .RD_PORTS(2)) u_ins_mem (
      .clock (clock),
      .we    (adv && a_we),
      .waddr (let_a),
      .wdata (a_wdata),
      .re    (adv),
      .raddr (rd_addr),
      .rdata (a_rd)
   );

   sac_ram #(.WIDTH(DIFF_W), .DEPTH(ALPHABET), .RD_PORTS(2)) u_rem_mem (
      .clock (clock),
      .we    (adv && b_we),
      .waddr (s2_old_ff),
      .wdata (b_wdata),
      .re    (adv),
      .raddr (rd_addr),
      .rdata (b_rd)
   );

   // operand select with forwarding
   always_comb begin
      let_a  = s2_item_ff.letter[HIST_AW-1:0];
      a_l    = pick(fwd_a_ff, let_a, va_ff[let_a], a_rd[0]);
      b_l    = pick(fwd_b_ff, let_a, vb_ff[let_a], b_rd[0]);
      a_o    = pick(fwd_a_ff, s2_old_ff, va_ff[s2_old_ff], a_rd[1]);
      b_o    = pick(fwd_b_ff, s2_old_ff, vb_ff[s2_old_ff], b_rd[1]);
      d_l    = a_l - b_l;
      d_o    = a_o - b_o;
      dl_inc = d_l + DIFF_W'(1);
      dl_dec = d_l - DIFF_W'(1);
      do_dec = d_o - DIFF_W'(1);
      same   = s2_item_ff.remove && (s2_old_ff == let_a);
   end

   // histogram update, mismatch count and total
   always_comb begin
      a_we     = 1'b0;
      b_we     = 1'b0;
      a_wdata  = a_l;
      b_wdata  = b_o + DIFF_W'(1);
      va_in    = va_ff;
      vb_in    = vb_ff;
      nz_in    = nz_ff;
      total_in = total_ff;
      match    = 1'b0;
      if (s2_item_ff.valid) begin
         case (s2_item_ff.act)
            ACT_CLEAR: begin
               va_in    = '0;
               vb_in    = '0;
               nz_in    = '0;
               total_in = '0;
            end
            ACT_PATTERN: begin
               a_we         = 1'b1;
               a_wdata      = a_l - DIFF_W'(1);
               va_in[let_a] = 1'b1;
               nz_in        = nz_ff - NZ_W'(d_l != '0) + NZ_W'(dl_dec != '0);
            end
            ACT_TEXT: begin
               a_we         = 1'b1;
               a_wdata      = a_l + DIFF_W'(1);
               va_in[let_a] = 1'b1;
               if (s2_item_ff.remove) begin
                  b_we             = 1'b1;
                  vb_in[s2_old_ff] = 1'b1;
               end
               // a letter leaving and entering at once leaves the difference alone
               if (!same) begin
                  nz_in = nz_ff - NZ_W'(d_l != '0) + NZ_W'(dl_inc != '0);
                  if (s2_item_ff.remove) begin
                     nz_in = nz_in - NZ_W'(d_o != '0) + NZ_W'(do_dec != '0);
                  end
               end
               match = s2_item_ff.full && (nz_in == '0);
               if (match && (total_ff != '1)) begin
                  total_in = total_ff + TOTAL_W'(1);
               end
            end
            default: ;
         endcase
      end
      fwd_a_in = '{valid: a_we, addr: let_a, data: a_wdata};
      fwd_b_in = '{valid: b_we, addr: s2_old_ff, data: b_wdata};
   end

   assign s2_item_in = s1_item;
   assign s2_old_in  = s1_old[HIST_AW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_item_ff.valid <= 1'b0;
         va_ff            <= '0;
         vb_ff            <= '0;
         fwd_a_ff.valid   <= 1'b0;
         fwd_b_ff.valid   <= 1'b0;
         nz_ff            <= '0;
         total_ff         <= '0;
      end else if (adv) begin
         s2_item_ff <= s2_item_in;
         va_ff      <= va_in;
         vb_ff      <= vb_in;
         fwd_a_ff   <= fwd_a_in;
         fwd_b_ff   <= fwd_b_in;
         nz_ff      <= nz_in;
         total_ff   <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_old_ff <= s2_old_in;
      end
   end

   assign s2_valid = s2_item_ff.valid;
   assign s2_rsp   = '{window_full: s2_item_ff.full, is_match: match,
                       match_total: total_in};

endmodule
